/* rtl/ssm_pkg.sv */
// shared types and constants of the saliency score map
`default_nettype none

package ssm_pkg;

	// default and reset map size
	localparam int MAP_SIZE_DEF  = 32;
	localparam int MAP_DIM_RESET = 32;

	// configuration port
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = CFG_IDX_W'(1);

	// item fields
	localparam int PIX_W      = 8;
	localparam int RGB_W      = 3 * PIX_W;
	localparam int COORD_W    = 5;
	localparam int SCORE_W    = 13;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	// position of a pixel and the border cases it hits
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               col0;
		logic               col1;
		logic               row0;
		logic               row1;
		logic               last_col;
		logic               last_row;
	} pos_t;

	// one column of the scoring window: luma of rows y-2, y-1, y and rgb of rows y-1, y
	typedef struct packed {
		logic [PIX_W-1:0] lt;
		logic [PIX_W-1:0] lm;
		logic [PIX_W-1:0] lb;
		logic [RGB_W-1:0] cm;
		logic [RGB_W-1:0] cb;
	} col_t;

endpackage

`default_nettype wire

/* rtl/saliency_score_map.sv */
// top level of the saliency score map
//
// Pixels enter on the s_ stream in raster order, one rgb item per beat.
// Scores leave on the m_ stream with their coordinates; tlast marks the
// last result caused by an input item, tuser marks the final result of the map.
// Pixel (x,y) is scored when the input one row and one column later arrives;
// last row and last column pixels are scored on the inputs that close them,
// so one input gives zero to four results.
// The first result of an item passes s1, the scoring window, s3 and the
// output register. An item giving n results holds the result sequencer
// until its last result is emitted. On maps one column wide an item waits
// until the luma of the row above has been written to the line store.
// The configuration port sets map width (index 0) and height (index 1);
// a write restarts the map at pixel (0,0).
// Reset empties the pipeline, zeroes the position counters and sets both
// sizes to 32; the line stores are not cleared and never read before written.
// When the receiver stalls, the output register holds its item, the internal
// stages fill up and s_tready drops.
`default_nettype none

module saliency_score_map #(
	parameter int MAP_SIZE = ssm_pkg::MAP_SIZE_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [ssm_pkg::IN_DATA_W-1:0]    s_tdata,   // red, green, blue
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [ssm_pkg::OUT_DATA_W-1:0]   m_tdata,   // score, out_x, out_y, zero pad
	output logic                             m_tlast,   // last_of_run
	output logic [0:0]                       m_tuser,   // frame_done
	input  wire                              cfg_write,
	input  wire  [ssm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [ssm_pkg::CFG_W-1:0]        cfg_data
);
	import ssm_pkg::*;

	localparam int CW   = $clog2(MAP_SIZE);
	localparam int SZW  = $clog2(MAP_SIZE + 1);
	localparam int CMPW = (CFG_W > SZW) ? CFG_W : SZW;
	localparam int LAW  = $clog2(3 * MAP_SIZE);
	localparam int RAW  = $clog2(2 * MAP_SIZE);

	// luma = (299r + 587g + 114b + 500) / 1000, the division as reciprocal multiply
	localparam int SUM_W  = 18;
	localparam int RCP_W  = 19;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam logic [SUM_W-1:0] W_RED      = SUM_W'(299);
	localparam logic [SUM_W-1:0] W_GREEN    = SUM_W'(587);
	localparam logic [SUM_W-1:0] W_BLUE     = SUM_W'(114);
	localparam logic [SUM_W-1:0] LUMA_ROUND = SUM_W'(500);
	localparam logic [RCP_W-1:0] LUMA_RECIP = RCP_W'(268436);
	localparam int               LUMA_SHIFT = 28;

	// clamp a size register to 1..MAP_SIZE and give the last index
	function automatic logic [CW-1:0] last_idx(input logic [CFG_W-1:0] v);
		logic [CMPW-1:0] e;
		e = CMPW'(v);
		if (e == '0) begin
			return '0;
		end else if (e > CMPW'(MAP_SIZE)) begin
			return CW'(MAP_SIZE - 1);
		end else begin
			return CW'(e - CMPW'(1));
		end
	endfunction

	function automatic logic [LAW-1:0] luma_addr(input logic [1:0] slot, input logic [CW-1:0] x);
		return LAW'(slot) * LAW'(MAP_SIZE) + LAW'(x);
	endfunction

	logic [CW-1:0] x_q, y_q, lastx_q, lasty_q;
	logic [1:0] slot_q, slot_mid, slot_top;
	logic accept, hazard, col_ready, s1_adv;
	pos_t pos_cur;
	logic [LAW-1:0] la_top, la_mid, la_cur;
	logic [RAW-1:0] ra_cur, ra_mid;
	logic [SUM_W-1:0] sum_cur;
	logic [RGB_W-1:0] rgb_cur;

	logic valid_s1;
	pos_t pos_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [RGB_W-1:0] rgb_s1;
	logic [LAW-1:0] la_s1;

	logic [PROD_W-1:0] prod;
	logic [PIX_W-1:0] luma, luma_top, luma_mid;
	logic [RGB_W-1:0] rgb_mid;
	col_t col;

	// position of the incoming pixel and its line-store addresses
	always_comb begin
		pos_cur.x        = COORD_W'(x_q);
		pos_cur.y        = COORD_W'(y_q);
		pos_cur.col0     = (x_q == '0);
		pos_cur.col1     = (x_q == CW'(1));
		pos_cur.row0     = (y_q == '0);
		pos_cur.row1     = (y_q == CW'(1));
		pos_cur.last_col = (x_q == lastx_q);
		pos_cur.last_row = (y_q == lasty_q);
		slot_mid = (slot_q == 2'd0) ? 2'd2 : slot_q - 2'd1;
		slot_top = (slot_q == 2'd0) ? 2'd1 : ((slot_q == 2'd1) ? 2'd2 : 2'd0);
		la_cur   = luma_addr(slot_q, x_q);
		la_mid   = luma_addr(slot_mid, x_q);
		la_top   = luma_addr(slot_top, x_q);
		ra_cur   = y_q[0] ? RAW'(MAP_SIZE) + RAW'(x_q) : RAW'(x_q);
		ra_mid   = y_q[0] ? RAW'(x_q) : RAW'(MAP_SIZE) + RAW'(x_q);
		rgb_cur  = {s_tdata[PIX_W-1:0], s_tdata[2*PIX_W-1:PIX_W], s_tdata[3*PIX_W-1:2*PIX_W]};
		sum_cur  = SUM_W'(s_tdata[PIX_W-1:0]) * W_RED
		         + SUM_W'(s_tdata[2*PIX_W-1:PIX_W]) * W_GREEN
		         + SUM_W'(s_tdata[3*PIX_W-1:2*PIX_W]) * W_BLUE
		         + LUMA_ROUND;
	end

	// hold off a read of the luma entry still waiting in s1 to be written
	assign hazard   = valid_s1 && ((la_s1 == la_top) || (la_s1 == la_mid));
	assign s1_adv   = valid_s1 && col_ready;
	assign s_tready = (!valid_s1 || col_ready) && !hazard;
	assign accept   = s_tvalid && s_tready;

	// size registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lastx_q <= last_idx(CFG_W'(MAP_DIM_RESET));
			lasty_q <= last_idx(CFG_W'(MAP_DIM_RESET));
			x_q     <= '0;
			y_q     <= '0;
			slot_q  <= 2'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MAP_WIDTH: begin
					lastx_q <= last_idx(cfg_data);
					x_q     <= '0;
					y_q     <= '0;
					slot_q  <= 2'd0;
				end
				REG_MAP_HEIGHT: begin
					lasty_q <= last_idx(cfg_data);
					x_q     <= '0;
					y_q     <= '0;
					slot_q  <= 2'd0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (pos_cur.last_col) begin
				x_q <= '0;
				if (pos_cur.last_row) begin
					y_q    <= '0;
					slot_q <= 2'd0;
				end else begin
					y_q    <= y_q + CW'(1);
					slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
				end
			end else begin
				x_q <= x_q + CW'(1);
			end
		end
	end

	// s1: item waits for the line-store reads and its luma
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= pos_cur;
			sum_s1 <= sum_cur;
			rgb_s1 <= rgb_cur;
			la_s1  <= la_cur;
		end
	end

	// luma by reciprocal multiply, exact over the whole sum range
	assign prod = PROD_W'(sum_s1) * PROD_W'(LUMA_RECIP);
	assign luma = PIX_W'(prod >> LUMA_SHIFT);

	assign col.lt = luma_top;
	assign col.lm = luma_mid;
	assign col.lb = luma;
	assign col.cm = rgb_mid;
	assign col.cb = rgb_s1;

	ssm_line_store #(
		.MAP_SIZE (MAP_SIZE)
	) u_line_store (
		.clk           (clk),
		.rd_en         (accept),
		.luma_top_addr (la_top),
		.luma_mid_addr (la_mid),
		.rgb_rd_addr   (ra_mid),
		.luma_we       (s1_adv),
		.luma_wr_addr  (la_s1),
		.luma_wr_data  (luma),
		.rgb_we        (accept),
		.rgb_wr_addr   (ra_cur),
		.rgb_wr_data   (rgb_cur),
		.luma_top      (luma_top),
		.luma_mid      (luma_mid),
		.rgb_mid       (rgb_mid)
	);

	ssm_score u_score (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_valid (valid_s1),
		.col_ready (col_ready),
		.col_in    (col),
		.pos_in    (pos_s1),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

/* rtl/ssm_line_store.sv */
// line stores for luma (three rows) and rgb (two rows) with registered reads
`default_nettype none

module ssm_line_store #(
	parameter int MAP_SIZE = ssm_pkg::MAP_SIZE_DEF,
	localparam int LAW = $clog2(3 * MAP_SIZE),
	localparam int RAW = $clog2(2 * MAP_SIZE)
) (
	input  wire                         clk,
	input  wire                         rd_en,
	input  wire  [LAW-1:0]              luma_top_addr,
	input  wire  [LAW-1:0]              luma_mid_addr,
	input  wire  [RAW-1:0]              rgb_rd_addr,
	input  wire                         luma_we,
	input  wire  [LAW-1:0]              luma_wr_addr,
	input  wire  [ssm_pkg::PIX_W-1:0]   luma_wr_data,
	input  wire                         rgb_we,
	input  wire  [RAW-1:0]              rgb_wr_addr,
	input  wire  [ssm_pkg::RGB_W-1:0]   rgb_wr_data,
	output logic [ssm_pkg::PIX_W-1:0]   luma_top,
	output logic [ssm_pkg::PIX_W-1:0]   luma_mid,
	output logic [ssm_pkg::RGB_W-1:0]   rgb_mid
);
	import ssm_pkg::*;

	logic [PIX_W-1:0] luma_mem [3 * MAP_SIZE];
	logic [RGB_W-1:0] rgb_mem  [2 * MAP_SIZE];

	// luma store: one write, two reads
	always_ff @(posedge clk) begin
		if (luma_we) begin
			luma_mem[luma_wr_addr] <= luma_wr_data;
		end
		if (rd_en) begin
			luma_top <= luma_mem[luma_top_addr];
			luma_mid <= luma_mem[luma_mid_addr];
		end
	end

	// rgb store: one write, one read
	always_ff @(posedge clk) begin
		if (rgb_we) begin
			rgb_mem[rgb_wr_addr] <= rgb_wr_data;
		end
		if (rd_en) begin
			rgb_mid <= rgb_mem[rgb_rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/ssm_score.sv */
// scoring window, result sequencer and output register
`default_nettype none

module ssm_score (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              col_valid,
	output logic                             col_ready,
	input  wire  ssm_pkg::col_t              col_in,
	input  wire  ssm_pkg::pos_t              pos_in,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [ssm_pkg::OUT_DATA_W-1:0]   m_tdata,  // score, out_x, out_y, zero pad
	output logic                             m_tlast,  // last_of_run
	output logic [0:0]                       m_tuser   // frame_done
);
	import ssm_pkg::*;

	localparam int LAP_W = PIX_W + 3;
	localparam int PAD_W = OUT_DATA_W - SCORE_W - 2 * COORD_W;

	// one-hot result kinds, in emission order
	localparam logic [3:0] RES_UP_LEFT = 4'b0001;
	localparam logic [3:0] RES_UP      = 4'b0010;
	localparam logic [3:0] RES_LEFT    = 4'b0100;
	localparam logic [3:0] RES_HERE    = 4'b1000;

	localparam logic [PIX_W-1:0]   LUMA_FLOOR  = PIX_W'(5);
	localparam logic [PIX_W-1:0]   SKIN_R      = PIX_W'(95);
	localparam logic [PIX_W-1:0]   SKIN_G      = PIX_W'(40);
	localparam logic [PIX_W-1:0]   SKIN_B      = PIX_W'(20);
	localparam logic [PIX_W-1:0]   SKIN_SPREAD = PIX_W'(15);
	localparam logic [PIX_W-1:0]   SKIN_RG     = PIX_W'(15);
	localparam logic [SCORE_W-1:0] SKIN_BONUS  = SCORE_W'(180);
	localparam logic [SCORE_W-1:0] GRAD_GAIN   = SCORE_W'(5);

	col_t w0_q, w1_q, w2_q;
	pos_t pos_q;
	logic [3:0] pend_q;

	logic [3:0] sel, pend_rest;
	logic emit, res_last;
	logic out_take, s3_take;
	logic [PIX_W-1:0] c, l, r, t, b;
	logic [RGB_W-1:0] rgb;
	logic [COORD_W-1:0] ox, oy;
	logic [PIX_W-1:0] red, green, blue, mx, mn, spread;
	logic skin;
	logic [LAP_W-1:0] lap;

	logic valid_s3, cgate_s3, skin_s3, last_s3, done_s3;
	logic [LAP_W-1:0] lap_s3;
	logic [PIX_W-1:0] spread_s3;
	logic [COORD_W-1:0] ox_s3, oy_s3;

	logic [LAP_W-1:0] mag;
	logic [SCORE_W-1:0] score;

	// handshake between scoring, s3 and the output register
	assign out_take  = !m_tvalid || m_tready;
	assign s3_take   = !valid_s3 || out_take;
	assign sel       = pend_q & (~pend_q + 4'd1);
	assign pend_rest = pend_q & ~sel;
	assign emit      = (pend_q != 4'd0) && s3_take;
	assign res_last  = (pend_rest == 4'd0);
	assign col_ready = (pend_q == 4'd0) || (emit && res_last);

	// window shift and pending results of the item in scoring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 4'd0;
		end else if (col_valid && col_ready) begin
			pend_q <= {pos_in.last_row && pos_in.last_col,
			           pos_in.last_row && !pos_in.col0,
			           !pos_in.row0 && pos_in.last_col,
			           !pos_in.row0 && !pos_in.col0};
		end else if (emit) begin
			pend_q <= pend_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (col_valid && col_ready) begin
			w0_q  <= col_in;
			w1_q  <= w0_q;
			w2_q  <= w1_q;
			pos_q <= pos_in;
		end
	end

	// operands of the selected result, with replicated borders
	always_comb begin
		c   = '0;
		l   = '0;
		r   = '0;
		t   = '0;
		b   = '0;
		rgb = '0;
		ox  = '0;
		oy  = '0;
		case (sel)
			RES_UP_LEFT: begin
				c   = w1_q.lm;
				l   = pos_q.col1 ? w1_q.lm : w2_q.lm;
				r   = w0_q.lm;
				t   = pos_q.row1 ? w1_q.lm : w1_q.lt;
				b   = w1_q.lb;
				rgb = w1_q.cm;
				ox  = pos_q.x - COORD_W'(1);
				oy  = pos_q.y - COORD_W'(1);
			end
			RES_UP: begin
				c   = w0_q.lm;
				l   = pos_q.col0 ? w0_q.lm : w1_q.lm;
				r   = w0_q.lm;
				t   = pos_q.row1 ? w0_q.lm : w0_q.lt;
				b   = w0_q.lb;
				rgb = w0_q.cm;
				ox  = pos_q.x;
				oy  = pos_q.y - COORD_W'(1);
			end
			RES_LEFT: begin
				c   = w1_q.lb;
				l   = pos_q.col1 ? w1_q.lb : w2_q.lb;
				r   = w0_q.lb;
				t   = pos_q.row0 ? w1_q.lb : w1_q.lm;
				b   = w1_q.lb;
				rgb = w1_q.cb;
				ox  = pos_q.x - COORD_W'(1);
				oy  = pos_q.y;
			end
			RES_HERE: begin
				c   = w0_q.lb;
				l   = pos_q.col0 ? w0_q.lb : w1_q.lb;
				r   = w0_q.lb;
				t   = pos_q.row0 ? w0_q.lb : w0_q.lm;
				b   = w0_q.lb;
				rgb = w0_q.cb;
				ox  = pos_q.x;
				oy  = pos_q.y;
			end
			default: begin
			end
		endcase
	end

	// laplacian, colour spread and skin test
	always_comb begin
		red    = rgb[3*PIX_W-1:2*PIX_W];
		green  = rgb[2*PIX_W-1:PIX_W];
		blue   = rgb[PIX_W-1:0];
		mx     = (red > green) ? ((red > blue) ? red : blue) : ((green > blue) ? green : blue);
		mn     = (red < green) ? ((red < blue) ? red : blue) : ((green < blue) ? green : blue);
		spread = mx - mn;
		skin   = (red > SKIN_R) && (green > SKIN_G) && (blue > SKIN_B)
		         && (spread > SKIN_SPREAD) && (red > green) && (red > blue)
		         && ((red - green) > SKIN_RG);
		lap    = LAP_W'({c, 2'b00}) - LAP_W'(l) - LAP_W'(r) - LAP_W'(t) - LAP_W'(b);
	end

	// s3 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_take) begin
			valid_s3 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_take && emit) begin
			lap_s3    <= lap;
			cgate_s3  <= (c > LUMA_FLOOR);
			spread_s3 <= spread;
			skin_s3   <= skin;
			ox_s3     <= ox;
			oy_s3     <= oy;
			last_s3   <= res_last;
			done_s3   <= res_last && pos_q.last_row && pos_q.last_col;
		end
	end

	// final score: five times the gradient, plus colour and skin bonus when the centre luma is above the floor
	always_comb begin
		mag   = lap_s3[LAP_W-1] ? (~lap_s3 + LAP_W'(1)) : lap_s3;
		score = SCORE_W'(mag) * GRAD_GAIN;
		if (cgate_s3) begin
			score = score + SCORE_W'(spread_s3) + (skin_s3 ? SKIN_BONUS : SCORE_W'(0));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_take) begin
			m_tvalid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && valid_s3) begin
			m_tdata <= {{PAD_W{1'b0}}, oy_s3, ox_s3, score};
			m_tlast <= last_s3;
			m_tuser <= done_s3;
		end
	end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench of the saliency score map: own score predictor, random traffic
`timescale 1ns / 1ps

module testbench;
	import ssm_pkg::*;

	// spare register index, writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(2);
	localparam int MAP_MAX = MAP_SIZE_DEF;
	localparam int LONG_HOLD = 250;

	// one expected result item
	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               run_end;
		logic               map_end;
	} score_item_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;   // red, green, blue
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;        // score, out_x, out_y, zero pad
	logic                   m_tlast;        // last_of_run
	logic [0:0]             m_tuser;        // frame_done
	logic                   cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	// predictor state
	logic [PIX_W-1:0]  luma_mem [0:3*MAP_MAX-1];
	logic [RGB_W-1:0]  rgb_mem [0:2*MAP_MAX-1];
	logic [CFG_W-1:0]  map_w_cfg;
	logic [CFG_W-1:0]  map_h_cfg;
	int                col_pos;
	int                row_pos;
	score_item_t       pending_scores[$];

	// traffic control
	bit  tx_idle_on = 1'b1;
	bit  rx_idle_on = 1'b1;
	bit  hold_request = 1'b0;
	int  hold_left = 0;
	int  rx_wait = 0;
	int  errors = 0;
	int  random_sent = 0;

	saliency_score_map i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 50 MHz clock
	initial begin
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("saliency_score_map regression: fail");
		$finish;
	end

	// size register as the block uses it
	function automatic int eff_dim(logic [CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAP_MAX) return MAP_MAX;
		return int'(v);
	endfunction

	function automatic int luma_at(int x, int y);
		return int'(luma_mem[(y % 3) * MAP_MAX + x]);
	endfunction

	// laplacian edge term plus colorfulness and skin bonus of one stored pixel
	function automatic score_item_t scored(int x, int y, int w, int h);
		int xl, xr, yt, yb, c, lap, r, g, b, mx, mn, rg, s;
		logic [RGB_W-1:0] px;
		score_item_t res;
		xl = (x > 0) ? x - 1 : 0;
		xr = (x + 1 < w) ? x + 1 : w - 1;
		yt = (y > 0) ? y - 1 : 0;
		yb = (y + 1 < h) ? y + 1 : h - 1;
		c = luma_at(x, y);
		lap = 4 * c - luma_at(xl, y) - luma_at(xr, y) - luma_at(x, yt) - luma_at(x, yb);
		if (lap < 0) lap = -lap;
		s = 5 * lap;
		if (c > 5) begin
			px = rgb_mem[(y % 2) * MAP_MAX + x];
			r = int'(px[23:16]);
			g = int'(px[15:8]);
			b = int'(px[7:0]);
			mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
			mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
			rg = (r > g) ? r - g : g - r;
			s += mx - mn;
			if (r > 95 && g > 40 && b > 20 && mx - mn > 15 && rg > 15 && r > g && r > b)
				s += 180;
		end
		res = '0;
		res.score = SCORE_W'(s);
		res.x = COORD_W'(x);
		res.y = COORD_W'(y);
		return res;
	endfunction

	// store one accepted pixel and queue the scores it releases
	task automatic predict_pixel(input logic [RGB_W-1:0] px);
		int w, h, x, y, r, g, b;
		bit col_end, row_end;
		score_item_t run[$];
		w = eff_dim(map_w_cfg);
		h = eff_dim(map_h_cfg);
		x = col_pos;
		y = row_pos;
		if (x >= w || y >= h) begin
			x = 0;
			y = 0;
		end
		col_end = (x == w - 1);
		row_end = (y == h - 1);
		r = int'(px[23:16]);
		g = int'(px[15:8]);
		b = int'(px[7:0]);
		luma_mem[(y % 3) * MAP_MAX + x] = PIX_W'((299 * r + 587 * g + 114 * b + 500) / 1000);
		rgb_mem[(y % 2) * MAP_MAX + x] = px;
		if (y >= 1) begin
			if (x >= 1) run.push_back(scored(x - 1, y - 1, w, h));
			if (col_end) run.push_back(scored(x, y - 1, w, h));
		end
		if (row_end) begin
			if (x >= 1) run.push_back(scored(x - 1, y, w, h));
			if (col_end) run.push_back(scored(x, y, w, h));
		end
		if (run.size() > 0) begin
			run[run.size() - 1].run_end = 1'b1;
			run[run.size() - 1].map_end = row_end && col_end;
		end
		foreach (run[i]) pending_scores.push_back(run[i]);
		if (col_end) begin
			col_pos = 0;
			row_pos = row_end ? 0 : y + 1;
		end else begin
			col_pos = x + 1;
			row_pos = y;
		end
	endtask

	// offer one pixel item {red, green, blue}; called and returns at a falling edge
	task automatic send_pixel(input logic [RGB_W-1:0] px);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {px[7:0], px[15:8], px[23:16]};
		do @(posedge clk); while (!s_tready);
		predict_pixel(px);
		@(negedge clk);
	endtask

	// stop offering and let every pending score come out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_scores.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_MAP_WIDTH) begin
			map_w_cfg = val;
			col_pos = 0;
			row_pos = 0;
		end else if (idx == REG_MAP_HEIGHT) begin
			map_h_cfg = val;
			col_pos = 0;
			row_pos = 0;
		end
		@(negedge clk);
	endtask

	task automatic set_map(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		write_reg(REG_MAP_WIDTH, w);
		write_reg(REG_MAP_HEIGHT, h);
	endtask

	// random pixel: saturated corners, skin tones, near-black or anything
	function automatic logic [RGB_W-1:0] pick_pixel();
		logic [7:0] r, g, b;
		case ($urandom_range(0, 5))
			0: begin
				r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			1: begin
				r = 8'($urandom_range(90, 255));
				g = 8'($urandom_range(35, r - 10));
				b = 8'($urandom_range(15, r));
			end
			2: begin
				r = 8'($urandom_range(0, 24));
				g = 8'($urandom_range(0, 6));
				b = 8'($urandom_range(0, 20));
			end
			default: {r, g, b} = RGB_W'($urandom);
		endcase
		return {r, g, b};
	endfunction

	// reset sizes: 32 wide, so pixel (0,0) is scored on the 34th item
	task automatic test_reset_size();
		repeat (34) send_pixel(pick_pixel());
		drain();
	endtask

	// one-pixel map: field extremes, luma threshold and skin test borders
	task automatic test_single_pixel();
		set_map(6'd1, 6'd1);
		send_pixel({8'd0, 8'd0, 8'd0});
		send_pixel({8'd255, 8'd255, 8'd255});
		send_pixel({8'd255, 8'd0, 8'd0});
		send_pixel({8'd0, 8'd255, 8'd0});
		send_pixel({8'd0, 8'd0, 8'd255});
		// luma 6 adds colorfulness, luma 5 does not
		send_pixel({8'd19, 8'd0, 8'd0});
		send_pixel({8'd18, 8'd0, 8'd0});
		// just inside and just outside the skin box
		send_pixel({8'd96, 8'd41, 8'd21});
		send_pixel({8'd95, 8'd41, 8'd21});
		drain();
	endtask

	// bright skin pixel in a dark 3x3 window, spare register written mid-map
	task automatic test_window();
		set_map(6'd3, 6'd3);
		repeat (4) send_pixel({8'd0, 8'd0, 8'd0});
		drain();
		write_reg(REG_UNUSED, 6'h3F);
		send_pixel({8'd255, 8'd235, 8'd200});
		repeat (4) send_pixel({8'd0, 8'd0, 8'd0});
		drain();
	endtask

	// widest single row and tallest single column, sizes above range and zero
	task automatic test_extreme_sizes();
		set_map(6'd63, 6'd1);
		repeat (32) begin
			send_pixel(pick_pixel());
			random_sent++;
		end
		drain();
		set_map(6'd0, 6'd63);
		repeat (32) begin
			send_pixel(pick_pixel());
			random_sent++;
		end
		drain();
	endtask

	// receiver holds off long while the sender keeps offering
	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		set_map(6'd5, 6'd4);
		@(posedge clk) hold_request = 1'b1;
		@(negedge clk);
		repeat (16) begin
			send_pixel(pick_pixel());
			random_sent++;
		end
		drain();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// small random maps, whole and cut short, restarted by the next size write
	task automatic test_random_maps(input int target);
		int wv, hv, area, n;
		while (random_sent < target) begin
			wv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
			hv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			set_map(CFG_W'(wv), CFG_W'(hv));
			area = eff_dim(CFG_W'(wv)) * eff_dim(CFG_W'(hv));
			n = area * $urandom_range(1, 2);
			if ($urandom_range(0, 2) == 0) n += $urandom_range(1, area);
			// keep the total item count near its budget
			if (n > target - random_sent) n = target - random_sent;
			repeat (n) begin
				send_pixel(pick_pixel());
				random_sent++;
			end
			drain();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// receiver: long hold first, then the per-item stall
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// compare each result item with the oldest expected score
	always @(posedge clk) begin : result_check
		score_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_scores.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, expected nothing, actual score %0d at (%0d,%0d)",
					$time, m_tdata[12:0], m_tdata[17:13], m_tdata[22:18]);
			end else begin
				want = pending_scores.pop_front();
				check_field("score", int'(want.score), int'(m_tdata[12:0]));
				check_field("out_x", int'(want.x), int'(m_tdata[17:13]));
				check_field("out_y", int'(want.y), int'(m_tdata[22:18]));
				check_field("last_of_run", int'(want.run_end), int'(m_tlast));
				check_field("frame_done", int'(want.map_end), int'(m_tuser[0]));
			end
			rx_wait = rx_idle_on ? $urandom_range(0, 16) : 0;
		end
	end

	// main sequence
	initial begin
		foreach (luma_mem[i]) luma_mem[i] = '0;
		foreach (rgb_mem[i]) rgb_mem[i] = '0;
		map_w_cfg = CFG_W'(MAP_DIM_RESET);
		map_h_cfg = CFG_W'(MAP_DIM_RESET);
		col_pos = 0;
		row_pos = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_size();
		test_single_pixel();
		test_window();
		test_extreme_sizes();
		test_backpressure();
		test_random_maps(92);

		drain();
		if (errors == 0) begin
			$display("saliency_score_map regression: pass");
		end else begin
			$display("saliency_score_map regression: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/ssm_pkg.sv
rtl/ssm_line_store.sv
rtl/ssm_score.sv
rtl/saliency_score_map.sv
tb/testbench.sv
